### design/dfd_pkg.sv
// Package for the delimiter frame decoder: register indexes, delimiter
// modes, byte constants and the word types passed between front and back.
// No dependencies.
package dfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_DELIM_MODE    = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_FRAME_LEN = 2'd1;
  localparam logic [IDX_W-1:0] REG_STRIP_DELIM   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_LINE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NUL  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CR   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LF   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CRLF = 3'd4;

  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

  localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 16'd8192;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_DATA,
    KIND_DONE
  } kind_t;

  // One classified input byte: an optional released CR, then one action.
  typedef struct packed {
    logic              rel_cr;
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic              crlf;
  } op_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              byte_valid;
    logic              frame_end;
    logic              frame_error;
  } res_t;

endpackage

### design/dfd_front.sv
// Front end of the delimiter frame decoder: accepts bytes, tracks a held
// CR and classifies each byte into an operation word for the queue.
// Depends on dfd_pkg.
module dfd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [dfd_pkg::MODE_W-1:0]     delim_mode,
  input  logic                           in_valid,
  input  logic [dfd_pkg::BYTE_W-1:0]     in_byte,
  output logic                           in_ready,
  output logic                           push,
  output dfd_pkg::op_t                   push_op,
  input  logic                           queue_ready
);
  import dfd_pkg::*;

  logic              cr_pending;
  logic              cr_pending_next;
  logic              holds_cr;
  logic              line_mode;
  logic [BYTE_W-1:0] delim_byte;

  assign in_ready = queue_ready;
  assign push     = in_valid && queue_ready;

  // Line and CRLF modes hold a CR back; unused codes behave as line mode.
  assign holds_cr  = (delim_mode == MODE_LINE) || (delim_mode >= MODE_CRLF);
  assign line_mode = (delim_mode == MODE_LINE) || (delim_mode > MODE_CRLF);

  always_comb begin
    unique case (delim_mode)
      MODE_NUL: delim_byte = CH_NUL;
      MODE_CR:  delim_byte = CH_CR;
      default:  delim_byte = CH_LF;
    endcase
  end

  always_comb begin
    push_op.rel_cr  = 1'b0;
    push_op.kind    = KIND_DATA;
    push_op.data    = in_byte;
    push_op.crlf    = 1'b0;
    cr_pending_next = 1'b0;
    if (cr_pending && holds_cr && in_byte == CH_LF) begin
      push_op.kind = KIND_DONE;
      push_op.crlf = 1'b1;
    end else begin
      push_op.rel_cr = cr_pending;
      if (holds_cr) begin
        if (in_byte == CH_CR) begin
          push_op.kind    = KIND_NONE;
          cr_pending_next = 1'b1;
        end else if (line_mode && in_byte == CH_LF) begin
          push_op.kind = KIND_DONE;
        end
      end else if (in_byte == delim_byte) begin
        push_op.kind = KIND_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cr_pending <= 1'b0;
    end else if (push) begin
      cr_pending <= cr_pending_next;
    end
  end

endmodule

### design/dfd_queue.sv
// Short queue of operation words between the front and back ends of the
// delimiter frame decoder. Depends on dfd_pkg.
module dfd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  dfd_pkg::op_t push_op,
  output logic         push_ready,
  input  logic         pop,
  output dfd_pkg::op_t pop_op,
  output logic         pop_valid
);
  import dfd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  op_t           entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/dfd_back.sv
// Back end of the delimiter frame decoder: executes operation words,
// keeps the frame length and discard state, and holds up to two results
// in an output buffer. Depends on dfd_pkg.
module dfd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [dfd_pkg::LEN_W-1:0]   max_frame_len,
  input  logic                        strip_delim,
  input  logic                        op_valid,
  input  dfd_pkg::op_t                op,
  output logic                        op_pop,
  output logic                        out_valid,
  output dfd_pkg::res_t               out_res,
  input  logic                        out_ready
);
  import dfd_pkg::*;

  logic [LEN_W-1:0] frame_count;
  logic             discarding;
  logic [LEN_W-1:0] frame_count_next;
  logic             discarding_next;
  res_t             res [2];
  logic [1:0]       res_n;
  res_t             slot0;
  res_t             slot1;
  logic [1:0]       fill;
  logic             taken;

  // Up to two actions per word: a released CR, then the byte's own action.
  always_comb begin
    frame_count_next = frame_count;
    discarding_next  = discarding;
    res[0] = '0;
    res[1] = '0;
    res_n  = 2'd0;
    if (op.rel_cr && !discarding_next) begin
      if (frame_count_next >= max_frame_len) begin
        discarding_next = 1'b1;
      end else begin
        frame_count_next = frame_count_next + 1'b1;
        res[0] = '{data: CH_CR, byte_valid: 1'b1, frame_end: 1'b0, frame_error: 1'b0};
        res_n  = 2'd1;
      end
    end
    unique case (op.kind)
      KIND_DATA: begin
        if (!discarding_next) begin
          if (frame_count_next >= max_frame_len) begin
            discarding_next = 1'b1;
          end else begin
            frame_count_next = frame_count_next + 1'b1;
            res[res_n[0]] = '{data: op.data, byte_valid: 1'b1, frame_end: 1'b0,
                              frame_error: 1'b0};
            res_n = res_n + 2'd1;
          end
        end
      end
      KIND_DONE: begin
        if (discarding_next) begin
          res[res_n[0]] = '{data: '0, byte_valid: 1'b0, frame_end: 1'b1, frame_error: 1'b1};
          res_n = res_n + 2'd1;
        end else if (strip_delim) begin
          res[res_n[0]] = '{data: '0, byte_valid: 1'b0, frame_end: 1'b1, frame_error: 1'b0};
          res_n = res_n + 2'd1;
        end else begin
          if (op.crlf) begin
            res[0] = '{data: CH_CR, byte_valid: 1'b1, frame_end: 1'b0, frame_error: 1'b0};
            res_n  = 2'd1;
          end
          res[res_n[0]] = '{data: op.data, byte_valid: 1'b1, frame_end: 1'b1,
                            frame_error: 1'b0};
          res_n = res_n + 2'd1;
        end
        frame_count_next = '0;
        discarding_next  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign out_valid = (fill != 2'd0);
  assign out_res   = slot0;
  assign taken     = out_valid && out_ready;
  // A new word is taken once the buffer drains this cycle.
  assign op_pop    = op_valid && ((fill == 2'd0) || (fill == 2'd1 && taken));

  always_ff @(posedge clk) begin
    if (op_pop) begin
      slot0 <= res[0];
      slot1 <= res[1];
    end else if (taken) begin
      slot0 <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= 2'd0;
      frame_count <= '0;
      discarding  <= 1'b0;
    end else begin
      if (op_pop) begin
        fill        <= res_n;
        frame_count <= frame_count_next;
        discarding  <= discarding_next;
      end else if (taken) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

### design/delimiter_frame_decoder_unit.sv
// Delimiter frame decoder: cuts a byte stream into frames at a chosen
// delimiter, passing frame bytes straight through.
//
// Input stream (s_*): one raw byte per word in s_tdata.
// Output stream (m_*): m_tdata carries the frame byte, m_tuser[0] says a
// byte is present (0 is a bare end marker), m_tuser[1] flags a frame that
// went past the maximum length, and m_tlast marks the last word of a frame.
// Configuration port (cfg_*): index 0 delimiter mode, 1 maximum frame
// length, 2 delimiter strip; cfg_ready is always high, other indexes are
// ignored. Write it only while the block is idle.
// An accepted byte is registered in the operation queue and then in the
// output buffer. One byte is taken per cycle while the queue has room; a
// byte that yields two words (a released CR plus a byte, or CR LF passed
// on) holds the output port for both, since it moves one word a cycle.
// A stalled receiver fills the output buffer and then the operation queue
// (QUEUE_DEPTH words) before s_tready drops. Reset empties the queue and
// buffer, drops any held CR and loads mode line, length 8192, strip on.
// Depends on dfd_pkg, dfd_front, dfd_queue and dfd_back.
module delimiter_frame_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] in_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] out_byte
  output logic [1:0]                    m_tuser,   // [0] byte_valid, [1] frame_error
  output logic                          m_tlast,   // frame_end
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dfd_pkg::IDX_W-1:0]     cfg_index,
  input  logic [dfd_pkg::LEN_W-1:0]     cfg_data
);
  import dfd_pkg::*;

  logic [MODE_W-1:0] delim_mode;
  logic [LEN_W-1:0]  max_frame_len;
  logic              strip_delim;
  logic              push;
  op_t               push_op;
  logic              queue_ready;
  logic              pop;
  op_t               pop_op;
  logic              pop_valid;
  res_t              out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_mode    <= MODE_LINE;
      max_frame_len <= MAX_LEN_RESET;
      strip_delim   <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DELIM_MODE:    delim_mode    <= cfg_data[MODE_W-1:0];
        REG_MAX_FRAME_LEN: max_frame_len <= cfg_data;
        REG_STRIP_DELIM:   strip_delim   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  dfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .delim_mode  (delim_mode),
    .in_valid    (s_tvalid),
    .in_byte     (s_tdata),
    .in_ready    (s_tready),
    .push        (push),
    .push_op     (push_op),
    .queue_ready (queue_ready)
  );

  dfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .push_ready (queue_ready),
    .pop        (pop),
    .pop_op     (pop_op),
    .pop_valid  (pop_valid)
  );

  dfd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .max_frame_len (max_frame_len),
    .strip_delim   (strip_delim),
    .op_valid      (pop_valid),
    .op            (pop_op),
    .op_pop        (pop),
    .out_valid     (m_tvalid),
    .out_res       (out_res),
    .out_ready     (m_tready)
  );

  assign m_tdata = out_res.data;
  assign m_tuser = {out_res.frame_error, out_res.byte_valid};
  assign m_tlast = out_res.frame_end;

endmodule

### tb/dfd_frame_checker.sv
// Frame checker for the delimiter frame decoder: watches the input, output and
// configuration channels, predicts every output word and compares it.
// Depends on dfd_pkg.
module dfd_frame_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [dfd_pkg::BYTE_W-1:0]   s_tdata,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [dfd_pkg::BYTE_W-1:0]   m_tdata,
  input  logic [1:0]                   m_tuser,
  input  logic                         m_tlast,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [dfd_pkg::IDX_W-1:0]    cfg_index,
  input  logic [dfd_pkg::LEN_W-1:0]    cfg_data,
  output int                           mismatches,
  output int                           outstanding
);
  import dfd_pkg::*;

  logic [MODE_W-1:0] mode;
  logic [LEN_W-1:0]  max_len;
  logic              strip;

  logic              cr_held;
  logic [16:0]       byte_count;
  logic              dropping;

  res_t frame_words_q[$];

  task automatic add_word(input logic [BYTE_W-1:0] d, input logic v, input logic e,
                          input logic err);
    res_t w;
    w.data        = d;
    w.byte_valid  = v;
    w.frame_end   = e;
    w.frame_error = err;
    frame_words_q = {frame_words_q, w};
  endtask

  task automatic pass_data(input logic [BYTE_W-1:0] b);
    if (dropping) return;
    // The byte that would exceed the limit is dropped and the frame is lost.
    if (byte_count >= {1'b0, max_len}) begin
      dropping = 1'b1;
      return;
    end
    byte_count = byte_count + 17'd1;
    add_word(b, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic end_frame(input logic [BYTE_W-1:0] b, input logic pair);
    if (dropping) begin
      add_word('0, 1'b0, 1'b1, 1'b1);
    end else if (strip) begin
      add_word('0, 1'b0, 1'b1, 1'b0);
    end else begin
      if (pair) add_word(CH_CR, 1'b1, 1'b0, 1'b0);
      add_word(b, 1'b1, 1'b1, 1'b0);
    end
    byte_count = '0;
    dropping   = 1'b0;
  endtask

  function automatic logic waits_for_lf(input logic [MODE_W-1:0] m);
    return (m == MODE_LINE) || (m >= MODE_CRLF);
  endfunction

  task automatic predict_byte(input logic [BYTE_W-1:0] b);
    logic              hold;
    logic              lone_lf;
    logic [BYTE_W-1:0] delim;
    hold    = waits_for_lf(mode);
    lone_lf = hold && (mode != MODE_CRLF);
    if (cr_held) begin
      cr_held = 1'b0;
      if (hold && b == CH_LF) begin
        end_frame(CH_LF, 1'b1);
        return;
      end
      pass_data(CH_CR);
    end
    if (hold) begin
      if (b == CH_CR) cr_held = 1'b1;
      else if (lone_lf && b == CH_LF) end_frame(CH_LF, 1'b0);
      else pass_data(b);
    end else begin
      delim = (mode == MODE_NUL) ? CH_NUL : (mode == MODE_CR) ? CH_CR : CH_LF;
      if (b == delim) end_frame(b, 1'b0);
      else pass_data(b);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst) begin
      mode       = MODE_LINE;
      max_len    = MAX_LEN_RESET;
      strip      = 1'b1;
      cr_held    = 1'b0;
      byte_count = '0;
      dropping   = 1'b0;
      frame_words_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DELIM_MODE:    mode    = cfg_data[MODE_W-1:0];
          REG_MAX_FRAME_LEN: max_len = cfg_data;
          REG_STRIP_DELIM:   strip   = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        got.data        = m_tdata;
        got.byte_valid  = m_tuser[0];
        got.frame_end   = m_tlast;
        got.frame_error = m_tuser[1];
        if (frame_words_q.size() == 0) begin
          $display("%0t: unexpected output word: data %02h valid %b end %b error %b",
                   $time, got.data, got.byte_valid, got.frame_end, got.frame_error);
          mismatches++;
        end else begin
          want = frame_words_q.pop_front();
          if (got !== want) begin
            $display({"%0t: output word mismatch: expected data %02h valid %b end %b",
                      " error %b, got data %02h valid %b end %b error %b"},
                     $time, want.data, want.byte_valid, want.frame_end, want.frame_error,
                     got.data, got.byte_valid, got.frame_end, got.frame_error);
            mismatches++;
          end
        end
      end
    end
    outstanding = frame_words_q.size();
  end

endmodule

### tb/tb_delimiter_frame_decoder_unit.sv
// Testbench top for delimiter_frame_decoder_unit: drives bytes and register
// writes with random gaps and stalls, and gives the verdict from the checker.
// Depends on dfd_pkg, delimiter_frame_decoder_unit and dfd_frame_checker.
module tb_delimiter_frame_decoder_unit;
  import dfd_pkg::*;

  localparam logic [IDX_W-1:0]  REG_UNUSED   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE   = 3'd7;
  localparam int                RANDOM_ITEMS = 600;
  localparam int                QUIET_LIMIT  = 4000;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [BYTE_W-1:0] s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [BYTE_W-1:0] m_tdata;
  logic [1:0]        m_tuser;
  logic              m_tlast;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index;
  logic [LEN_W-1:0]  cfg_data;

  int mismatches;
  int outstanding;

  int tx_pct;
  int rx_pct;
  int rx_hold;
  int quiet;
  int bytes_sent;

  logic [MODE_W-1:0] cur_mode;
  logic [LEN_W-1:0]  cur_max;

  delimiter_frame_decoder_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dfd_frame_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Mostly short pauses, now and then a long one.
  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 50;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_pct) begin
      rx_hold  <= idle_len() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("delimiter_frame_decoder_unit regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    gap = ($urandom_range(0, 99) < tx_pct) ? idle_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A held CR gives no word until the next byte, so the task waits on past
  // the last expected word before registers change.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [MODE_W-1:0] m, input logic [LEN_W-1:0] lim,
                           input logic strip);
    wait_idle();
    write_reg(REG_DELIM_MODE, {13'($urandom), m});
    if ($urandom_range(0, 4) == 0) write_reg(REG_UNUSED, 16'($urandom));
    write_reg(REG_MAX_FRAME_LEN, lim);
    write_reg(REG_STRIP_DELIM, {15'($urandom), strip});
    cfg_valid <= 1'b0;
    cur_mode = m;
    cur_max  = lim;
  endtask

  task automatic send_delim();
    case (cur_mode)
      MODE_NUL: send_byte(CH_NUL);
      MODE_CR:  send_byte(CH_CR);
      MODE_LF:  send_byte(CH_LF);
      MODE_CRLF: begin
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      default: begin
        if ($urandom_range(0, 1) == 1) send_byte(CH_CR);
        send_byte(CH_LF);
      end
    endcase
  endtask

  task automatic send_frame();
    int                len;
    int                cap;
    logic [BYTE_W-1:0] b;
    cap = (cur_max < 16) ? int'(cur_max) + 3 : 12;
    len = $urandom_range(0, cap);
    repeat (len) begin
      b = 8'($urandom_range(0, 255));
      // Control bytes inside a frame are mostly moved out of the way.
      if ((b == CH_NUL || b == CH_LF || b == CH_CR) && $urandom_range(0, 3) != 0)
        b = b ^ 8'h40;
      send_byte(b);
    end
    send_delim();
  endtask

  task automatic send_noise();
    int                len;
    logic [BYTE_W-1:0] b;
    len = $urandom_range(1, 6);
    repeat (len) begin
      case ($urandom_range(0, 5))
        0:       b = CH_CR;
        1:       b = CH_LF;
        2:       b = CH_NUL;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b);
    end
  endtask

  task automatic run_phase();
    int                r;
    logic [MODE_W-1:0] m;
    logic [LEN_W-1:0]  lim;
    r = $urandom_range(0, 9);
    m = (r < 8) ? MODE_W'(r % 5) : MODE_W'($urandom_range(5, 7));
    case ($urandom_range(0, 7))
      0:       lim = '0;
      1:       lim = 16'd1;
      2:       lim = 16'hFFFF;
      3:       lim = MAX_LEN_RESET;
      4:       lim = 16'($urandom_range(0, 65535));
      default: lim = 16'($urandom_range(2, 12));
    endcase
    tx_pct = pick_pct();
    rx_pct = pick_pct();
    configure(m, lim, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(3, 10)) begin
      if ($urandom_range(0, 6) == 0) send_noise();
      else send_frame();
    end
  endtask

  initial begin
    int random_start;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    m_tready   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    tx_pct     = 10;
    rx_pct     = 10;
    rx_hold    = 0;
    quiet      = 0;
    bytes_sent = 0;
    cur_mode   = MODE_LINE;
    cur_max    = MAX_LEN_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: line mode, stripped delimiters.
    send_byte(8'h41);
    send_byte(8'hFF);
    send_byte(CH_NUL);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_LF);
    // A CR followed by CR LF: the first is data, the pair ends the frame.
    send_byte(CH_CR);
    send_byte(CH_CR);
    send_byte(CH_LF);
    // A held CR that is not followed by LF goes out as data.
    send_byte(CH_CR);
    send_byte(8'h42);
    send_byte(CH_LF);

    // Zero length limit with delimiters kept: every non-empty frame fails.
    configure(MODE_LINE, '0, 1'b0);
    send_byte(8'h43);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte(CH_LF);

    // Leave a CR held, then switch to a mode that releases it.
    configure(MODE_LINE, 16'hFFFF, 1'b0);
    send_byte(CH_CR);
    configure(MODE_NUL, 16'd2, 1'b0);
    send_byte(CH_NUL);
    configure(MODE_SPARE, 16'd2, 1'b0);
    send_byte(CH_CR);
    send_byte(CH_LF);

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_ITEMS) run_phase();

    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("delimiter_frame_decoder_unit regression: pass");
    end else begin
      $display("delimiter_frame_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule

### delimiter_frame_decoder_unit.f
design/dfd_pkg.sv
design/dfd_front.sv
design/dfd_queue.sv
design/dfd_back.sv
design/delimiter_frame_decoder_unit.sv
tb/dfd_frame_checker.sv
tb/tb_delimiter_frame_decoder_unit.sv
